FILE: hdl/iol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types and codes for the indexed ordered list.
// ----------------------------------------------------------------------------
package iol_pkg;

	// request kinds
	localparam logic [2:0] REQ_INS_HEAD = 3'd0;
	localparam logic [2:0] REQ_INS_TAIL = 3'd1;
	localparam logic [2:0] REQ_INS_POS  = 3'd2;
	localparam logic [2:0] REQ_READ     = 3'd3;
	localparam logic [2:0] REQ_DEL_HEAD = 3'd4;
	localparam logic [2:0] REQ_DEL_TAIL = 3'd5;
	localparam logic [2:0] REQ_DEL_POS  = 3'd6;

	// response status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 5;

	typedef struct packed {
		logic [2:0]                req_type;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [1:0]                status;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic load;    // capture incoming request
		logic commit;  // apply request, load response register
	} ctrl_cmd_t;

endpackage

FILE: hdl/iol_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_ctrl
// Request sequencer: takes one request, executes it, hands the response
// to the output register when that register is free.
// ----------------------------------------------------------------------------
module iol_ctrl
	import iol_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        rsp_valid_q;
	logic        rsp_free;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ST_EXEC: begin
				cmd.commit = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

FILE: hdl/iol_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_datapath
// Row of entry cells with element count; decodes the held request,
// shifts the row up or down by one and builds the response.
// ----------------------------------------------------------------------------
module iol_datapath
	import iol_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  req_t      req,
	output rsp_t      rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	req_t                      req_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [VALUE_W-1:0] cells_q [CAPACITY];
	rsp_t                      rsp_q;

	logic [CMP_W-1:0]          cnt_ext;
	logic [CMP_W-1:0]          eff_pos;
	logic [CMP_W-1:0]          new_cnt;
	logic                      is_ins;
	logic                      is_del;
	logic                      op_ok;
	logic [1:0]                stat;
	logic signed [VALUE_W-1:0] rd_val;

	assign cnt_ext = CMP_W'(count_q);

	always_comb begin
		eff_pos = CMP_W'(req_q.position);
		case (req_q.req_type)
			REQ_INS_HEAD, REQ_DEL_HEAD: eff_pos = '0;
			REQ_INS_TAIL:               eff_pos = cnt_ext;
			REQ_DEL_TAIL:               eff_pos = cnt_ext - CMP_W'(1);
			default:                    eff_pos = CMP_W'(req_q.position);
		endcase
	end

	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		stat    = STAT_OK;
		rd_val  = '0;
		case (req_q.req_type)
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
				is_ins = 1'b1;
				if (eff_pos > cnt_ext) stat = STAT_INVALID;
				else if (cnt_ext >= CAP_C) stat = STAT_FULL;
			end
			REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
				is_del = 1'b1;
				if (count_q == '0) stat = STAT_EMPTY;
				else if (eff_pos >= cnt_ext) stat = STAT_INVALID;
			end
			REQ_READ: begin
				if (eff_pos < cnt_ext) begin
					rd_val = cells_q[eff_pos[IDX_W-1:0]];
				end else begin
					rd_val = '1;
					stat   = STAT_INVALID;
				end
			end
			default: begin
				stat = STAT_OK;
			end
		endcase
	end

	assign op_ok = (stat == STAT_OK);

	always_comb begin
		new_cnt = cnt_ext;
		if (op_ok && is_ins) new_cnt = cnt_ext + CMP_W'(1);
		else if (op_ok && is_del) new_cnt = cnt_ext - CMP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= new_cnt[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.commit) begin
			rsp_q.read_value <= rd_val;
			rsp_q.status     <= stat;
			rsp_q.count      <= new_cnt[COUNT_W-1:0];
		end
	end

	// each cell takes its neighbor below (insert), above (delete) or the new value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMP_W-1:0] I_C = CMP_W'(i);
		always_ff @(posedge clk) begin
			if (cmd.commit && op_ok) begin
				if (is_ins) begin
					if (I_C == eff_pos) cells_q[i] <= req_q.value;
					else if (I_C > eff_pos) cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end else if (is_del) begin
					if (I_C >= eff_pos && i < CAPACITY - 1)
						cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: hdl/indexed_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Ordered list of up to CAPACITY signed 32-bit values with positional
// insert, read and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries a request kind,
//   a position and a value. Response channel (rsp_valid / rsp_stall / rsp)
//   returns one response per request: read value, status and new count.
//   A request is taken when valid is high and stall is low.
//   The request is captured into the request register when it is taken;
//   the execute step then shifts the cell row and registers the response
//   once the output register is free. A new request is not taken until the
//   current one has executed; the whole cell row updates together, and the
//   sequencer alternates capture and execute.
//   The next request is taken while a response still waits in the output
//   register; execution holds only if that register is still occupied.
//   Reset empties the list (count to zero); cell contents are left as is.
//   While rsp_stall is high the response stays put and at most one more
//   request is taken and held.
// ----------------------------------------------------------------------------
module indexed_ordered_list
	import iol_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctrl_cmd_t cmd;

	iol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	iol_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	// a taken request blocks the next one for the execute cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken during execute");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |-> rsp.count == '0)
		else $error("empty status with nonzero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status without full count");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 31) || (32'(rsp.count) <= 32'(CAPACITY)))
		else $error("count above capacity");

endmodule
